/* rtl/core/multilevel_trilinear_interp_macros.svh */
// Assertion macros for the multilevel trilinear interpolator.
// Define NO_ASSERTIONS to compile them away; users must provide clk_i and rst_ni.
`ifndef MULTILEVEL_TRILINEAR_INTERP_MACROS_SVH
`define MULTILEVEL_TRILINEAR_INTERP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MTI_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mti assertion failed");
`define MTI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mti assertion failed");
`else
`define MTI_ASSERT_IMPLIES(lbl, ante, cons)
`define MTI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/mti_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types of the multilevel trilinear interpolator.
// No dependencies.
package mti_pkg;

  typedef logic signed [31:0] word_t;

  localparam logic [1:0] REQ_GEOM   = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [1:0] CFG_REFLECT = 2'd0;
  localparam logic [1:0] CFG_LEVELS  = 2'd1;

  localparam int GEOM_WORDS = 9;
  localparam int DIVIDEND_W = 33;
  localparam int DIVISOR_W  = 32;
  localparam int IDX_W      = 31;

endpackage

/* rtl/core/mti_ram.sv */
`timescale 1ns / 1ps
// Single-port-write, single-port-read synchronous RAM, registered read data.
// No dependencies.
module mti_ram #(
  parameter int DEPTH = 72,
  parameter int AW    = 7,
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/mti_divider.sv */
`timescale 1ns / 1ps
// Restoring radix-2 divider: integer quotient followed by FRAC_BITS fraction bits.
// Depends on mti_pkg.
module mti_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic [mti_pkg::DIVIDEND_W-1:0]           dividend_i,
  input  logic [mti_pkg::DIVISOR_W-1:0]            divisor_i,
  output logic                                     done_o,
  output logic [mti_pkg::DIVIDEND_W+FRAC_BITS-1:0] quot_o
);

  localparam int QW = mti_pkg::DIVIDEND_W + FRAC_BITS;
  localparam int RW = mti_pkg::DIVISOR_W;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0] a_q;
  logic [RW-1:0] r_q;
  logic [RW-1:0] d_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          ge;

  assign trial = {r_q, a_q[QW-1]};
  assign diff  = trial - {1'b0, d_q};
  assign ge    = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= {dividend_i, {FRAC_BITS{1'b0}}};
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      a_q <= {a_q[QW-2:0], ge};
      r_q <= ge ? diff[RW-1:0] : trial[RW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = a_q;

endmodule

/* rtl/core/multilevel_trilinear_interp.sv */
`timescale 1ns / 1ps
// Top level: multilevel trilinear interpolator over per-level geometry and grid RAMs.
// Depends on mti_pkg, mti_ram, mti_divider and the macros header.
//
//  channel | signals                                    | direction
//  in      | in_valid_i/in_ready_o + request fields     | upstream -> block
//  out     | out_valid_o/out_ready_i + result fields    | block -> downstream
//  cfg     | cfg_valid_i/cfg_ready_o, index, data       | host -> block
//
// Loads are taken in the idle state. A query, for each level tried, fetches the geometry,
// checks it and divides on up to 3 axes, then weights the eight corners; the bit-serial
// divider (one bit per cycle) and the one-read-per-cycle RAMs dominate its duration.
// One transaction is in progress at a time; a finished result sits in the output
// register, so the next request is taken while it waits.
// Reset clears control state and sets the batch flag; RAM contents are undefined until loaded.
`include "multilevel_trilinear_interp_macros.svh"

module multilevel_trilinear_interp #(
  parameter int LEVELS            = 8,
  parameter int SAMPLES_PER_LEVEL = 65536,
  parameter int FRAC_BITS         = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           req_type_i,
  input  logic [2:0]           level_sel_i,
  input  logic [3:0]           word_sel_i,
  input  logic [15:0]          sample_index_i,
  input  logic signed [31:0]   load_value_i,
  input  logic signed [31:0]   point_x_i,
  input  logic signed [31:0]   point_y_i,
  input  logic signed [31:0]   point_z_i,
  input  logic                 last_point_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   interp_value_o,
  output logic                 point_found_o,
  output logic [2:0]           level_used_o,
  output logic                 batch_found_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int GEO_DEPTH  = LEVELS * mti_pkg::GEOM_WORDS;
  localparam int GEO_AW     = $clog2(GEO_DEPTH);
  localparam int GRID_DEPTH = LEVELS * SAMPLES_PER_LEVEL;
  localparam int GRID_AW    = $clog2(GRID_DEPTH);
  localparam int TW         = $clog2(SAMPLES_PER_LEVEL);
  localparam int IW         = mti_pkg::IDX_W;
  localparam int QW         = mti_pkg::DIVIDEND_W + FRAC_BITS;
  localparam int WW         = FRAC_BITS + 1;
  localparam int MUL_W      = WW + 1 + 32;
  localparam int ACC_W      = FRAC_BITS + 36;
  localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] MAXV = $signed({{(ACC_W-32){1'b0}}, 32'h7fffffff});
  localparam logic signed [ACC_W-1:0] MINV = $signed({{(ACC_W-32){1'b1}}, 32'h80000000});

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GEO   = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_BOUND = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_C1    = 4'd6;
  localparam logic [3:0] S_C2    = 4'd7;
  localparam logic [3:0] S_C3    = 4'd8;
  localparam logic [3:0] S_C4    = 4'd9;
  localparam logic [3:0] S_C5    = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state_q;
  logic       reflect_q;
  logic [3:0] levels_q;
  logic       batch_ok_q;
  logic [3:0] cur_lev_q;
  logic [3:0] wc_q;
  logic [1:0] axis_q;
  logic [2:0] corner_q;
  logic       out_valid_q;

  mti_pkg::word_t geo_q [mti_pkg::GEOM_WORDS];
  mti_pkg::word_t r_q   [3];
  mti_pkg::word_t rw_q  [3];
  logic [IW-1:0]           lo_q [3];
  logic [IW-1:0]           hi_q [3];
  logic [FRAC_BITS-1:0]    w1_q [3];
  logic                    zneg_q;
  logic                    last_q;
  logic                    found_q;
  logic [2*IW-1:0]         bnd_q;
  logic [2*IW-1:0]         p_q;
  logic [TW+IW-1:0]        q_q;
  logic                    oob_q;
  logic                    zero_q;
  logic [2*WW-1:0]         wxy_q;
  logic [2*WW-1:0]         wtp_q;
  logic [WW-1:0]           wt_q;
  logic signed [MUL_W-1:0] mul_q;
  logic signed [ACC_W-1:0] acc_q;
  mti_pkg::word_t          sat_q;
  mti_pkg::word_t          val_out_q;
  logic                    found_out_q;
  logic [2:0]              lev_out_q;
  logic                    batch_out_q;

  logic                 in_fire;
  logic                 geo_we;
  logic [GEO_AW-1:0]    geo_waddr;
  logic [GEO_AW-1:0]    geo_raddr;
  logic                 geo_re;
  logic [31:0]          geo_rdata;
  logic                 grid_we;
  logic [GRID_AW-1:0]   grid_waddr;
  logic [GRID_AW-1:0]   grid_raddr;
  logic                 grid_re;
  logic [31:0]          grid_rdata;
  logic                 div_start;
  logic                 div_done;
  logic [QW-1:0]        div_quot;
  logic [mti_pkg::DIVIDEND_W-1:0] div_dividend;

  logic [4:0]           top_lev;
  mti_pkg::word_t       rz;
  logic                 bad_geom;
  logic                 contained;
  logic signed [63:0]   hi_bound;
  logic [IW-1:0]        cnt_m1;
  logic [IW-1:0]        idx_lo;
  logic [IW-1:0]        idx_hi;
  logic [IW-1:0]        i_sel;
  logic [IW-1:0]        j_sel;
  logic [IW-1:0]        k_sel;
  logic [WW-1:0]        wx;
  logic [WW-1:0]        wy;
  logic [WW-1:0]        wz;
  logic [2*IW:0]        t1;
  logic [TW+IW:0]       t2;
  logic                 out_free;
  logic signed [ACC_W-1:0] raw;
  mti_pkg::word_t       neg_val;
  logic                 ok_now;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign geo_we    = in_fire && (req_type_i == mti_pkg::REQ_GEOM) &&
                     (int'(level_sel_i) < LEVELS) &&
                     (int'(word_sel_i) < mti_pkg::GEOM_WORDS);
  assign geo_waddr = GEO_AW'(8'(level_sel_i) * 8'd9 + 8'(word_sel_i));
  assign geo_re    = (state_q == S_GEO) && (int'(wc_q) < mti_pkg::GEOM_WORDS);
  assign geo_raddr = GEO_AW'(8'(cur_lev_q) * 8'd9 + 8'(wc_q));

  assign grid_we    = in_fire && (req_type_i == mti_pkg::REQ_SAMPLE) &&
                      (int'(level_sel_i) < LEVELS) &&
                      (int'(sample_index_i) < SAMPLES_PER_LEVEL);
  assign grid_waddr = GRID_AW'(32'(level_sel_i) * 32'(SAMPLES_PER_LEVEL) +
                               32'(sample_index_i));

  mti_ram #(.DEPTH(GEO_DEPTH), .AW(GEO_AW), .DW(32)) u_geo_ram (
    .clk_i   (clk_i),
    .we_i    (geo_we),
    .waddr_i (geo_waddr),
    .wdata_i (load_value_i),
    .re_i    (geo_re),
    .raddr_i (geo_raddr),
    .rdata_o (geo_rdata)
  );

  mti_ram #(.DEPTH(GRID_DEPTH), .AW(GRID_AW), .DW(32)) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (grid_we),
    .waddr_i (grid_waddr),
    .wdata_i (load_value_i),
    .re_i    (grid_re),
    .raddr_i (grid_raddr),
    .rdata_o (grid_rdata)
  );

  mti_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (geo_q[3]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    top_lev = (int'(levels_q) > LEVELS) ? 5'(LEVELS) : {1'b0, levels_q};
    if (reflect_q && point_z_i[31]) begin
      rz = (point_z_i == 32'sh80000000) ? 32'sh7fffffff : -point_z_i;
    end else begin
      rz = point_z_i;
    end
    bad_geom = 1'b0;
    for (int d = 0; d < 3; d++) begin
      if (geo_q[3+d] <= 32'sd0 || geo_q[6+d] < 32'sd1) begin
        bad_geom = 1'b1;
      end
    end
    hi_bound  = 64'(geo_q[0]) + $signed({2'b00, bnd_q});
    contained = (rw_q[0] >= geo_q[0]) && (64'(rw_q[0]) <= hi_bound);
    div_dividend = {rw_q[0][31], rw_q[0]} - {geo_q[0][31], geo_q[0]};
    div_start = (state_q == S_CMP) && contained;
    cnt_m1 = IW'(geo_q[6] - 32'sd1);
    idx_lo = div_quot[FRAC_BITS +: IW];
    idx_hi = (idx_lo == cnt_m1) ? idx_lo : idx_lo + IW'(1);
    i_sel = corner_q[2] ? hi_q[0] : lo_q[0];
    j_sel = corner_q[1] ? hi_q[1] : lo_q[1];
    k_sel = corner_q[0] ? hi_q[2] : lo_q[2];
    wx = corner_q[2] ? {1'b0, w1_q[0]} : ONE - {1'b0, w1_q[0]};
    wy = corner_q[1] ? {1'b0, w1_q[1]} : ONE - {1'b0, w1_q[1]};
    wz = corner_q[0] ? {1'b0, w1_q[2]} : ONE - {1'b0, w1_q[2]};
    t1 = {1'b0, p_q} + (2*IW+1)'(j_sel);
    t2 = {1'b0, q_q} + (TW+IW+1)'(k_sel);
    grid_re = (state_q == S_C3) && !(oob_q || (t2 >= (TW+IW+1)'(SAMPLES_PER_LEVEL)));
    grid_raddr = GRID_AW'(32'(cur_lev_q) * 32'(SAMPLES_PER_LEVEL) + 32'(t2[TW-1:0]));
    raw = acc_q >>> FRAC_BITS;
    neg_val = (sat_q == 32'sh80000000) ? 32'sh7fffffff : -sat_q;
    ok_now = batch_ok_q && found_q;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      reflect_q   <= 1'b0;
      levels_q    <= 4'd1;
      batch_ok_q  <= 1'b1;
      cur_lev_q   <= '0;
      wc_q        <= '0;
      axis_q      <= '0;
      corner_q    <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          mti_pkg::CFG_REFLECT: reflect_q <= cfg_data_i[0];
          mti_pkg::CFG_LEVELS:  levels_q  <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire && req_type_i == mti_pkg::REQ_QUERY) begin
            found_q <= 1'b0;
            wc_q    <= '0;
            if (top_lev == 5'd0) begin
              state_q <= S_OUT;
            end else begin
              cur_lev_q <= 4'(top_lev - 5'd1);
              state_q   <= S_GEO;
            end
          end
        end
        S_GEO: begin
          wc_q <= wc_q + 4'd1;
          if (int'(wc_q) == mti_pkg::GEOM_WORDS) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          axis_q <= '0;
          if (bad_geom) begin
            wc_q <= '0;
            if (cur_lev_q == 4'd0) begin
              state_q <= S_OUT;
            end else begin
              cur_lev_q <= cur_lev_q - 4'd1;
              state_q   <= S_GEO;
            end
          end else begin
            state_q <= S_BOUND;
          end
        end
        S_BOUND: state_q <= S_CMP;
        S_CMP: begin
          if (contained) begin
            state_q <= S_DIV;
          end else begin
            wc_q <= '0;
            if (cur_lev_q == 4'd0) begin
              state_q <= S_OUT;
            end else begin
              cur_lev_q <= cur_lev_q - 4'd1;
              state_q   <= S_GEO;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (axis_q == 2'd2) begin
              corner_q <= '0;
              state_q  <= S_C1;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= S_BOUND;
            end
          end
        end
        S_C1: state_q <= S_C2;
        S_C2: state_q <= S_C3;
        S_C3: state_q <= S_C4;
        S_C4: state_q <= S_C5;
        S_C5: begin
          corner_q <= corner_q + 3'd1;
          state_q  <= (corner_q == 3'd7) ? S_FIN : S_C1;
        end
        S_FIN: begin
          found_q <= 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            batch_ok_q  <= last_q ? 1'b1 : ok_now;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      r_q[0] <= point_x_i;
      r_q[1] <= point_y_i;
      r_q[2] <= rz;
      zneg_q <= reflect_q && point_z_i[31];
      last_q <= last_point_i;
      sat_q  <= '0;
    end
    if (state_q == S_GEO && wc_q != 4'd0) begin
      for (int w = 0; w < mti_pkg::GEOM_WORDS - 1; w++) begin
        geo_q[w] <= geo_q[w+1];
      end
      geo_q[mti_pkg::GEOM_WORDS-1] <= geo_rdata;
    end
    if (state_q == S_CHECK) begin
      for (int d = 0; d < 3; d++) begin
        rw_q[d] <= r_q[d];
      end
    end
    if (state_q == S_BOUND) begin
      bnd_q <= geo_q[3][IW-1:0] * cnt_m1;
    end
    if (state_q == S_DIV && div_done) begin
      lo_q[0] <= lo_q[1];
      lo_q[1] <= lo_q[2];
      lo_q[2] <= idx_lo;
      hi_q[0] <= hi_q[1];
      hi_q[1] <= hi_q[2];
      hi_q[2] <= idx_hi;
      w1_q[0] <= w1_q[1];
      w1_q[1] <= w1_q[2];
      w1_q[2] <= div_quot[FRAC_BITS-1:0];
      rw_q[0] <= rw_q[1];
      rw_q[1] <= rw_q[2];
      rw_q[2] <= rw_q[0];
      for (int t = 0; t < 3; t++) begin
        geo_q[3*t]   <= geo_q[3*t+1];
        geo_q[3*t+1] <= geo_q[3*t+2];
        geo_q[3*t+2] <= geo_q[3*t];
      end
      acc_q <= '0;
    end
    if (state_q == S_C1) begin
      p_q   <= i_sel * geo_q[7][IW-1:0];
      wxy_q <= wx * wy;
    end
    if (state_q == S_C2) begin
      oob_q <= t1 >= (2*IW+1)'(SAMPLES_PER_LEVEL);
      q_q   <= t1[TW-1:0] * geo_q[8][IW-1:0];
      wtp_q <= wxy_q[FRAC_BITS +: WW] * wz;
    end
    if (state_q == S_C3) begin
      zero_q <= !grid_re;
      wt_q   <= wtp_q[FRAC_BITS +: WW];
    end
    if (state_q == S_C4) begin
      mul_q <= $signed({1'b0, wt_q}) * $signed(zero_q ? 32'd0 : grid_rdata);
    end
    if (state_q == S_C5) begin
      acc_q <= acc_q + {{(ACC_W-MUL_W){mul_q[MUL_W-1]}}, mul_q};
    end
    if (state_q == S_FIN) begin
      if (raw > MAXV) begin
        sat_q <= 32'sh7fffffff;
      end else if (raw < MINV) begin
        sat_q <= 32'sh80000000;
      end else begin
        sat_q <= raw[31:0];
      end
    end
    if (state_q == S_OUT && out_free) begin
      val_out_q   <= (found_q && zneg_q) ? neg_val : sat_q;
      found_out_q <= found_q;
      lev_out_q   <= found_q ? cur_lev_q[2:0] : 3'd0;
      batch_out_q <= last_q && ok_now;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign interp_value_o = val_out_q;
  assign point_found_o  = found_out_q;
  assign level_used_o   = lev_out_q;
  assign batch_found_o  = batch_out_q;

  `MTI_ASSERT_IMPLIES(a_batch_needs_found, out_valid_o && batch_found_o, point_found_o)
  `MTI_ASSERT_IMPLIES(a_miss_is_zero, out_valid_o && !point_found_o, interp_value_o == 32'sd0 && level_used_o == 3'd0)
  `MTI_ASSERT_IMPLIES(a_div_done_in_wait, div_done, state_q == S_DIV)
  `MTI_ASSERT_NEXT(a_load_stays_idle, in_fire && req_type_i != mti_pkg::REQ_QUERY, state_q == S_IDLE)

endmodule

/* sim/mti_checker.sv */
`timescale 1ns / 1ps
// Checker for the multilevel trilinear interpolator: watches the request, result and
// register channels, predicts each query result and compares it. Depends on mti_pkg.
module mti_checker
  import mti_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  req_type_i,
  input  logic [2:0]  level_sel_i,
  input  logic [3:0]  word_sel_i,
  input  logic [15:0] sample_index_i,
  input  word_t       load_value_i,
  input  word_t       point_x_i,
  input  word_t       point_y_i,
  input  word_t       point_z_i,
  input  logic        last_point_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  word_t       interp_value_i,
  input  logic        point_found_i,
  input  logic [2:0]  level_used_i,
  input  logic        batch_found_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  localparam int NLEV = 8;
  localparam longint SPL = 65536;
  localparam longint ONE = 64'sd1 << 16;

  typedef struct packed {
    logic [31:0] value;
    logic        found;
    logic [2:0]  level;
    logic        batch;
  } interp_res_t;

  logic [31:0] geom_mem [NLEV*GEOM_WORDS];
  logic [31:0] grid_mem [longint];
  logic        batch_ok;
  logic        reflect_q;
  logic [3:0]  levels_q;
  interp_res_t expected_q[$];
  int          errors;

  assign errors_o  = errors;
  assign pending_o = expected_q.size();

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint geom_word(int lev, int w);
    return longint'(signed'(geom_mem[lev*GEOM_WORDS+w]));
  endfunction

  function automatic longint grid_read(int lev, longint n1, longint n2,
                                       longint i, longint j, longint k);
    longint unsigned t;
    t = longint'(i) * n1 + j;
    if (t >= SPL) return 0;
    t = t * n2 + k;
    if (t >= SPL) return 0;
    if (!grid_mem.exists(lev*SPL + t)) return 0;
    return longint'(signed'(grid_mem[lev*SPL + t]));
  endfunction

  function automatic bit level_hit(int lev, longint r[3], output longint v);
    longint n[3], lo[3], hi[3], w[3][2];
    longint org, sp, cnt, idx, rem, sum, wxy, wt;
    sum = 0;
    v = 0;
    for (int d = 0; d < 3; d++) begin
      org = geom_word(lev, d);
      sp  = geom_word(lev, 3 + d);
      cnt = geom_word(lev, 6 + d);
      if (sp <= 0 || cnt < 1) return 0;
      if (r[d] < org || r[d] > org + sp * (cnt - 1)) return 0;
      idx = (r[d] - org) / sp;
      rem = r[d] - org - idx * sp;
      n[d] = cnt;
      lo[d] = idx;
      hi[d] = (idx + 1 > cnt - 1) ? cnt - 1 : idx + 1;
      w[d][1] = (rem <<< 16) / sp;
      w[d][0] = ONE - w[d][1];
    end
    for (int a = 0; a < 2; a++)
      for (int b = 0; b < 2; b++)
        for (int c = 0; c < 2; c++) begin
          wxy = (w[0][a] * w[1][b]) >>> 16;
          wt  = (wxy * w[2][c]) >>> 16;
          sum += wt * grid_read(lev, n[1], n[2], a ? hi[0] : lo[0],
                                b ? hi[1] : lo[1], c ? hi[2] : lo[2]);
        end
    v = sum >>> 16;
    return 1;
  endfunction

  function automatic interp_res_t predict_query(word_t px, word_t py, word_t pz,
                                                logic last);
    interp_res_t res;
    longint r[3], z, v;
    int top;
    bit found, neg;
    found = 0;
    v = 0;
    res = '0;
    z = longint'(pz);
    neg = reflect_q && z < 0;
    r[0] = longint'(px);
    r[1] = longint'(py);
    r[2] = neg ? sat32(-z) : z;
    top = (levels_q > NLEV) ? NLEV : levels_q;
    for (int il = top - 1; il >= 0 && !found; il--) begin
      if (level_hit(il, r, v)) begin
        found = 1;
        res.level = il[2:0];
      end
    end
    if (found) begin
      v = sat32(v);
      if (neg) v = sat32(-v);
    end else begin
      v = 0;
    end
    batch_ok = batch_ok && found;
    res.value = v[31:0];
    res.found = found;
    res.batch = last && batch_ok;
    if (last) batch_ok = 1;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    interp_res_t exp_r;
    if (!rst_ni) begin
      batch_ok  = 1;
      reflect_q = 0;
      levels_q  = 4'd1;
      errors    = 0;
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no query pending: value %h", $time, interp_value_i);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (interp_value_i !== exp_r.value) begin
            $display("%0t: interp_value expected %h actual %h", $time, exp_r.value,
                     interp_value_i);
            errors++;
          end
          if (point_found_i !== exp_r.found) begin
            $display("%0t: point_found expected %b actual %b", $time, exp_r.found,
                     point_found_i);
            errors++;
          end
          if (level_used_i !== exp_r.level) begin
            $display("%0t: level_used expected %0d actual %0d", $time, exp_r.level,
                     level_used_i);
            errors++;
          end
          if (batch_found_i !== exp_r.batch) begin
            $display("%0t: batch_found expected %b actual %b", $time, exp_r.batch,
                     batch_found_i);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (req_type_i)
          REQ_GEOM:
            if (word_sel_i < GEOM_WORDS)
              geom_mem[level_sel_i*GEOM_WORDS + word_sel_i] = load_value_i;
          REQ_SAMPLE: grid_mem[level_sel_i*SPL + sample_index_i] = load_value_i;
          REQ_QUERY:
            expected_q.push_back(predict_query(point_x_i, point_y_i, point_z_i,
                                               last_point_i));
          default: ;
        endcase
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_REFLECT: reflect_q = cfg_data_i[0];
          CFG_LEVELS:  levels_q  = cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Testbench top: builds level geometry and grids, drives loads, queries and register
// writes under varying backpressure. Depends on mti_pkg, mti_checker and the block.
module tb;
  import mti_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 3000;

  logic        clk_i = 0;
  logic        rst_ni;
  logic        in_valid, in_ready;
  logic [1:0]  req_type;
  logic [2:0]  level_sel;
  logic [3:0]  word_sel;
  logic [15:0] sample_index;
  word_t       load_value, point_x, point_y, point_z;
  logic        last_point;
  logic        out_valid, out_ready;
  word_t       interp_value;
  logic        point_found, batch_found;
  logic [2:0]  level_used;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors, pending;
  int          send_idle, recv_idle, stall;

  longint org_t [8][3];
  longint sp_t  [8][3];
  longint cnt_t [8][3];
  bit     reflect_on;
  int     lev_tab [12] = '{0, 8, 15, 1, 8, 3, 1, 6, 15, 8, 2, 8};

  always #6 clk_i = ~clk_i;

  multilevel_trilinear_interp u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .req_type_i(req_type), .level_sel_i(level_sel), .word_sel_i(word_sel),
    .sample_index_i(sample_index), .load_value_i(load_value),
    .point_x_i(point_x), .point_y_i(point_y), .point_z_i(point_z),
    .last_point_i(last_point),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .interp_value_o(interp_value), .point_found_o(point_found),
    .level_used_o(level_used), .batch_found_o(batch_found),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  mti_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .req_type_i(req_type), .level_sel_i(level_sel), .word_sel_i(word_sel),
    .sample_index_i(sample_index), .load_value_i(load_value),
    .point_x_i(point_x), .point_y_i(point_y), .point_z_i(point_z),
    .last_point_i(last_point),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .interp_value_i(interp_value), .point_found_i(point_found),
    .level_used_i(level_used), .batch_found_i(batch_found),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) out_ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall <= 0;
    else
      stall <= stall + 1;
    if (stall > STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_req(logic [1:0] rt, logic [2:0] lv, logic [3:0] ws,
                          logic [15:0] si, word_t lval, word_t px, word_t py,
                          word_t pz, logic last);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    in_valid     <= 1;
    req_type     <= rt;
    level_sel    <= lv;
    word_sel     <= ws;
    sample_index <= si;
    load_value   <= lval;
    point_x      <= px;
    point_y      <= py;
    point_z      <= pz;
    last_point   <= last;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic load_geom(int lv, int w, longint v);
    send_req(REQ_GEOM, lv[2:0], w[3:0], 16'($urandom), v[31:0], $urandom, $urandom,
             $urandom, $urandom_range(1));
  endtask

  // Drains the block and then writes both registers in back-to-back transactions.
  task automatic set_regs(bit refl, int levs);
    in_valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_valid <= 1;
    cfg_index <= CFG_REFLECT;
    cfg_data  <= {$urandom_range(32'h7fff_ffff), refl};
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_index <= CFG_LEVELS;
    cfg_data  <= {$urandom_range(32'h0fff_ffff), levs[3:0]};
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 0;
    reflect_on = refl;
  endtask

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic build_levels(bit with_odd_loads);
    longint n;
    for (int lv = 0; lv < 8; lv++) begin
      for (int d = 0; d < 3; d++) begin
        org_t[lv][d] = longint'($urandom_range(32'h0020_0000)) - 64'sd1048576;
        case ($urandom_range(9))
          0: sp_t[lv][d] = 1;
          1: sp_t[lv][d] = 64'sd65536;
          2: sp_t[lv][d] = 64'sd1073741824;
          default: sp_t[lv][d] = $urandom_range(32'h0020_0000, 1);
        endcase
        cnt_t[lv][d] = $urandom_range(3, 1);
      end
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1)) sp_t[lv][$urandom_range(2)] = -longint'($urandom_range(5));
        else cnt_t[lv][$urandom_range(2)] = -longint'($urandom_range(3));
      end
      for (int d = 0; d < 3; d++) begin
        load_geom(lv, d, org_t[lv][d]);
        load_geom(lv, 3 + d, sp_t[lv][d]);
        load_geom(lv, 6 + d, cnt_t[lv][d]);
      end
      if (cnt_t[lv][0] >= 1 && cnt_t[lv][1] >= 1 && cnt_t[lv][2] >= 1) begin
        n = cnt_t[lv][0] * cnt_t[lv][1] * cnt_t[lv][2];
        for (int s = 0; s < n; s++)
          send_req(REQ_SAMPLE, lv[2:0], 4'($urandom), s[15:0],
                   ($urandom_range(3) == 0) ? 32'h7fff_ffff ^ {32{$urandom_range(1)}}
                                            : $urandom,
                   $urandom, $urandom, $urandom, $urandom_range(1));
      end
    end
    if (with_odd_loads) begin
      send_req(REQ_SAMPLE, 3'd7, 4'hf, 16'hffff, $urandom, 0, 0, 0, 1);
      for (int w = GEOM_WORDS; w < 16; w++) load_geom($urandom_range(7), w, $urandom);
      send_req(2'd3, 3'd7, 4'hf, 16'hffff, 32'hffff_ffff, -1, -1, -1, 1);
      send_req(2'd3, 3'd0, 4'h0, 16'h0000, 32'h0, 0, 0, 0, 0);
    end
  endtask

  task automatic send_query(int mode);
    longint r[3], span, off;
    int lv;
    lv = $urandom_range(7);
    for (int d = 0; d < 3; d++) begin
      span = sp_t[lv][d] * (cnt_t[lv][d] - 1);
      if (span <= 0) off = 0;
      else if (mode == 1) off = span;
      else off = longint'({$urandom, $urandom} >> 1) % (span + 1);
      r[d] = clamp32(org_t[lv][d] + off);
    end
    if (reflect_on && $urandom_range(1)) r[2] = clamp32(-r[2]);
    if (mode == 2) begin
      r[0] = longint'(word_t'($urandom));
      r[1] = longint'(word_t'($urandom));
      r[2] = longint'(word_t'($urandom));
    end
    send_req(REQ_QUERY, 3'($urandom), 4'($urandom), 16'($urandom), $urandom,
             r[0][31:0], r[1][31:0], r[2][31:0], $urandom_range(4) == 0);
  endtask

  initial begin
    rst_ni       <= 0;
    in_valid     <= 0;
    req_type     <= REQ_GEOM;
    level_sel    <= 0;
    word_sel     <= 0;
    sample_index <= 0;
    load_value   <= 0;
    point_x      <= 0;
    point_y      <= 0;
    point_z      <= 0;
    last_point   <= 0;
    cfg_valid    <= 0;
    cfg_index    <= CFG_REFLECT;
    cfg_data     <= 0;
    out_ready    <= 0;
    stall        <= 0;
    send_idle = 12;
    recv_idle = 65;
    reflect_on = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 12 : (ph == 1) ? 65 : 0;
      recv_idle = (ph == 0) ? 65 : (ph == 1) ? 12 : 0;
      build_levels(ph == 0);
      for (int sub = 0; sub < 4; sub++) begin
        set_regs((ph + sub) % 2, lev_tab[ph*4 + sub]);
        // edge points: extremes of the coordinates, exact level bounds, most negative z
        send_req(REQ_QUERY, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_req(REQ_QUERY, 7, 15, 16'hffff, -1, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h7fff_ffff, 1);
        send_req(REQ_QUERY, 0, 0, 0, 0, org_t[7][0][31:0], org_t[7][1][31:0],
                 org_t[7][2][31:0], 0);
        send_query(1);
        send_req(REQ_QUERY, 0, 0, 0, 0, org_t[0][0][31:0], org_t[0][1][31:0],
                 32'h8000_0000, 1);
        for (int q = 0; q < 85; q++)
          send_query(($urandom_range(9) < 2) ? 2 : ($urandom_range(9) == 0) ? 1 : 0);
      end
    end
    in_valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
